FILE: rtl/gait_clock_angle_generator_unit_defines.svh
// assertion macros for the gait clock angle generator checker
// used by gcag_checker; needs clock and reset in the scope of use
`ifndef GAIT_CLOCK_ANGLE_GENERATOR_UNIT_DEFINES_SVH
`define GAIT_CLOCK_ANGLE_GENERATOR_UNIT_DEFINES_SVH

// checked only outside reset
`define GCAG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define GCAG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/gcag_pkg.sv
// shared types and constants of the gait clock angle generator
// no dependencies
package gcag_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int ANGLE_W         = 56;
   localparam int DEG_W           = 9;
   localparam int MS_W            = 16;
   localparam int ELAPSED_W       = 31;
   localparam int WRAP_W          = 31;
   localparam int PERIOD_W        = MS_W + 1;
   localparam int MARK_W          = DEG_W + MS_W + 1;
   localparam int PROD_W          = DEG_W + MS_W;
   localparam int FRAC_W          = DEG_W + ANGLE_FRAC_BITS;
   localparam int QUO2_W          = 31;
   localparam int NUM2_W          = PROD_W + QUO2_W;
   localparam int TURN_W          = WRAP_W + DEG_W;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 31;

   localparam logic [DEG_W:0]      DEG_FULL  = 10'd360;
   localparam logic [DEG_W-1:0]    DEG_MAX   = 9'd359;
   localparam logic [MS_W-1:0]     SLOW_RST  = 16'd1000;
   localparam logic [MS_W-1:0]     FAST_RST  = 16'd1000;
   localparam logic [DEG_W-1:0]    START_RST = 9'd30;
   localparam logic [DEG_W-1:0]    END_RST   = 9'd60;
   localparam logic [WRAP_W-1:0]   WRAP_RST  = 31'h7fff_ffff;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOW_TIME  = 3'd0,
      CSR_FAST_TIME  = 3'd1,
      CSR_ARC_START  = 3'd2,
      CSR_ARC_END    = 3'd3,
      CSR_WRAP       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                  bad;
      logic [PERIOD_W-1:0]   period;
      logic [MS_W-1:0]       fast;
      logic [DEG_W-1:0]      arc_start;
      logic [DEG_W-1:0]      arc_end;
      logic [DEG_W-1:0]      arc_span;
      logic [DEG_W-1:0]      rest;
      logic [MARK_W-1:0]     start_mark;
      logic [MARK_W-1:0]     end_mark;
      logic [PROD_W-1:0]     slow_rest;
      logic [WRAP_W-1:0]     wrap;
   } cfg_type;

endpackage

FILE: rtl/gcag_cfg.sv
// configuration registers and the values derived from them
// depends on gcag_pkg
module gcag_cfg
   import gcag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [MS_W-1:0]   slow_ff, fast_ff;
   logic [DEG_W-1:0]  start_ff, end_ff;
   logic [WRAP_W-1:0] wrap_ff;
   logic [PROD_W-1:0] start_mark_ff, slow_rest_ff;
   logic [PROD_W-1:0] start_mark_in, slow_rest_in;
   logic [DEG_W-1:0]  span, rest;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_ff  <= SLOW_RST;
         fast_ff  <= FAST_RST;
         start_ff <= START_RST;
         end_ff   <= END_RST;
         wrap_ff  <= WRAP_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLOW_TIME: slow_ff  <= csr_wdata[MS_W-1:0];
            CSR_FAST_TIME: fast_ff  <= csr_wdata[MS_W-1:0];
            CSR_ARC_START: start_ff <= csr_wdata[DEG_W-1:0];
            CSR_ARC_END:   end_ff   <= csr_wdata[DEG_W-1:0];
            CSR_WRAP:      wrap_ff  <= csr_wdata[WRAP_W-1:0];
            default: ;
         endcase
      end
   end

   assign span = end_ff - start_ff;
   assign rest = DEG_W'(DEG_FULL - {1'b0, span});

   assign start_mark_in = PROD_W'(start_ff) * PROD_W'(fast_ff);
   assign slow_rest_in  = PROD_W'(slow_ff) * PROD_W'(rest);

   // products settle the cycle after a write, long before an item needs them
   always_ff @(posedge clock) begin
      start_mark_ff <= start_mark_in;
      slow_rest_ff  <= slow_rest_in;
   end

   always_comb begin
      cfg.bad = (slow_ff == '0) || (fast_ff == '0) || (wrap_ff == '0) ||
                (start_ff > DEG_MAX) || (end_ff > DEG_MAX) || (end_ff <= start_ff);
      cfg.period     = PERIOD_W'(slow_ff) + PERIOD_W'(fast_ff);
      cfg.fast       = fast_ff;
      cfg.arc_start  = start_ff;
      cfg.arc_end    = end_ff;
      cfg.arc_span   = span;
      cfg.rest       = rest;
      cfg.start_mark = MARK_W'(start_mark_ff);
      cfg.end_mark   = MARK_W'(start_mark_ff) + MARK_W'(slow_rest_ff);
      cfg.slow_rest  = slow_rest_ff;
      cfg.wrap       = wrap_ff;
   end

endmodule

FILE: rtl/gcag_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
// numerator must be below den << QUO_W; depends on nothing
module gcag_div_pipe #(
   parameter int DEN_W  = 17,
   parameter int QUO_W  = 31,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [DEN_W+QUO_W-1:0]   in_num,
   input  logic [DEN_W-1:0]         in_den,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic [QUO_W-1:0]         out_quo,
   output logic [DEN_W-1:0]         out_rem,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int NUM_W = DEN_W + QUO_W;

   logic [QUO_W-1:0]  vld_ff;
   logic [DEN_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  work_ff [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   logic [QUO_W:0]    vld_d;
   logic [DEN_W-1:0]  rem_d  [QUO_W+1];
   logic [QUO_W-1:0]  work_d [QUO_W+1];
   logic [DEN_W-1:0]  den_d  [QUO_W+1];
   logic [SIDE_W-1:0] side_d [QUO_W+1];

   assign vld_d[0]  = in_valid;
   assign rem_d[0]  = in_num[NUM_W-1:QUO_W];
   assign work_d[0] = in_num[QUO_W-1:0];
   assign den_d[0]  = in_den;
   assign side_d[0] = in_side;

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [DEN_W:0] shifted, diff;
      logic           ge;

      // work holds the numerator bits still to come on top, quotient bits below
      assign shifted = {rem_d[k], work_d[k][QUO_W-1]};
      assign ge      = shifted >= {1'b0, den_d[k]};
      assign diff    = shifted - {1'b0, den_d[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_d[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            work_ff[k] <= {work_d[k][QUO_W-2:0], ge};
            den_ff[k]  <= den_d[k];
            side_ff[k] <= side_d[k];
         end
      end

      assign vld_d[k+1]  = vld_ff[k];
      assign rem_d[k+1]  = rem_ff[k];
      assign work_d[k+1] = work_ff[k];
      assign den_d[k+1]  = den_ff[k];
      assign side_d[k+1] = side_ff[k];
   end

   assign out_valid = vld_d[QUO_W];
   assign out_quo   = work_d[QUO_W];
   assign out_rem   = rem_d[QUO_W];
   assign out_side  = side_d[QUO_W];

endmodule

FILE: rtl/gcag_seg.sv
// picks the segment of the rotation and builds the fraction division
// three stages: phase product, segment compare, numerator; depends on gcag_pkg
module gcag_seg
   import gcag_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  cfg_type                cfg,
   input  logic                   in_valid,
   input  logic [ELAPSED_W-1:0]   in_rot,
   input  logic [PERIOD_W-1:0]    in_phase,
   input  logic                   in_bad,
   output logic                   out_valid,
   output logic [ELAPSED_W-1:0]   out_rot,
   output logic                   out_bad,
   output logic [NUM2_W-1:0]      out_num,
   output logic [PROD_W-1:0]      out_den,
   output logic [FRAC_W-1:0]      out_base
);

   typedef enum logic [1:0] {
      SEG_FAST_IN,
      SEG_SLOW,
      SEG_FAST_OUT
   } seg_type;

   logic [2:0]            vld_ff;
   logic [ELAPSED_W-1:0]  rot1_ff, rot2_ff, rot3_ff;
   logic [2:0]            bad_ff;
   logic [MARK_W-1:0]     tw_ff, diff_ff, diff_in;
   seg_type               seg_ff, seg_in;
   logic [NUM2_W-1:0]     num_ff, num_in;
   logic [PROD_W-1:0]     den_ff, den_in;
   logic [FRAC_W-1:0]     base_ff, base_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   // a phase on a boundary takes the earlier segment
   always_comb begin
      if (tw_ff <= cfg.start_mark) begin
         seg_in  = SEG_FAST_IN;
         diff_in = tw_ff;
      end else if (tw_ff <= cfg.end_mark) begin
         seg_in  = SEG_SLOW;
         diff_in = tw_ff - cfg.start_mark;
      end else begin
         seg_in  = SEG_FAST_OUT;
         diff_in = tw_ff - cfg.end_mark;
      end
   end

   always_comb begin
      case (seg_ff)
         SEG_SLOW: begin
            num_in  = (NUM2_W'(diff_ff) * NUM2_W'(cfg.arc_span)) << ANGLE_FRAC_BITS;
            den_in  = cfg.slow_rest;
            base_in = {cfg.arc_start, ANGLE_FRAC_BITS'(0)};
         end
         SEG_FAST_OUT: begin
            num_in  = NUM2_W'(diff_ff) << ANGLE_FRAC_BITS;
            den_in  = PROD_W'(cfg.fast);
            base_in = {cfg.arc_end, ANGLE_FRAC_BITS'(0)};
         end
         default: begin
            num_in  = NUM2_W'(diff_ff) << ANGLE_FRAC_BITS;
            den_in  = PROD_W'(cfg.fast);
            base_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tw_ff   <= MARK_W'(in_phase) * MARK_W'(cfg.rest);
         rot1_ff <= in_rot;
         rot2_ff <= rot1_ff;
         rot3_ff <= rot2_ff;
         bad_ff  <= {bad_ff[1:0], in_bad};
         seg_ff  <= seg_in;
         diff_ff <= diff_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
         base_ff <= base_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_rot   = rot3_ff;
   assign out_bad   = bad_ff[2];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_base  = base_ff;

endmodule

FILE: rtl/gait_clock_angle_generator_unit.sv
// gait clock angle generator: elapsed time in, target leg angle out
// depends on gcag_pkg, gcag_cfg, gcag_div_pipe, gcag_seg
//
// req channel carries elapsed_ms; rsp channel carries angle_q16 (1/65536 deg)
// and config_error. csr_we/csr_index/csr_wdata write the five registers:
// slow time, fast time, arc start, arc end, wrap rotations.
// from req accept to rsp valid: 31 stages divide time by the period, 3 stages
// pick the segment, then 31 stages divide the in-segment fraction while a
// parallel 31-stage unit reduces the rotations by the wrap count, and 2 stages
// scale, add and register the result.
// throughput is one item per cycle while the output is not stalled; the whole pipe advances together.
// when rsp_tready is low with a result waiting, every stage holds and
// req_tready drops; nothing is lost or repeated.
// reset empties the pipe and loads the register defaults (1000 ms, 1000 ms,
// 30 deg, 60 deg, 2147483647 rotations); no clearing pass.
// an invalid register set gives angle 0 with config_error high.
module gait_clock_angle_generator_unit
   import gcag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [30:0] elapsed_ms
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // [55:0] angle_q16, [56] config_error
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type               cfg;
   logic                  adv;

   logic                  d1_valid, d1_bad;
   logic [ELAPSED_W-1:0]  d1_quo;
   logic [PERIOD_W-1:0]   d1_rem;

   logic                  s_valid, s_bad;
   logic [ELAPSED_W-1:0]  s_rot;
   logic [NUM2_W-1:0]     s_num;
   logic [PROD_W-1:0]     s_den;
   logic [FRAC_W-1:0]     s_base;

   logic                  d2_valid, d3_valid, d3_bad;
   logic [QUO2_W-1:0]     d2_quo;
   logic [FRAC_W-1:0]     d2_base;
   logic [WRAP_W-1:0]     d3_rem;

   logic                  f_valid_ff, f_bad_ff;
   logic [TURN_W-1:0]     turn_ff;
   logic [FRAC_W-1:0]     frac_ff;

   logic                  rsp_valid_ff;
   logic [ANGLE_W-1:0]    angle_ff, angle_in;
   logic                  err_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   gcag_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gcag_div_pipe #(.DEN_W(PERIOD_W), .QUO_W(ELAPSED_W), .SIDE_W(1)) u_div_period (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_num    ({PERIOD_W'(0), req_tdata[ELAPSED_W-1:0]}),
      .in_den    (cfg.period),
      .in_side   (cfg.bad),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_rem   (d1_rem),
      .out_side  (d1_bad)
   );

   gcag_seg u_seg (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg),
      .in_valid  (d1_valid),
      .in_rot    (d1_quo),
      .in_phase  (d1_rem),
      .in_bad    (d1_bad),
      .out_valid (s_valid),
      .out_rot   (s_rot),
      .out_bad   (s_bad),
      .out_num   (s_num),
      .out_den   (s_den),
      .out_base  (s_base)
   );

   gcag_div_pipe #(.DEN_W(PROD_W), .QUO_W(QUO2_W), .SIDE_W(FRAC_W)) u_div_frac (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s_valid),
      .in_num    (s_num),
      .in_den    (s_den),
      .in_side   (s_base),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_rem   (),
      .out_side  (d2_base)
   );

   // whole rotations reduced by the wrap count; the fraction never reaches 360
   gcag_div_pipe #(.DEN_W(WRAP_W), .QUO_W(ELAPSED_W), .SIDE_W(1)) u_div_wrap (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s_valid),
      .in_num    ({WRAP_W'(0), s_rot}),
      .in_den    (cfg.wrap),
      .in_side   (s_bad),
      .out_valid (d3_valid),
      .out_quo   (),
      .out_rem   (d3_rem),
      .out_side  (d3_bad)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff   <= d2_valid && d3_valid;
         rsp_valid_ff <= f_valid_ff;
      end
   end

   assign angle_in = f_bad_ff ? '0 :
                     ANGLE_W'({turn_ff, ANGLE_FRAC_BITS'(0)}) + ANGLE_W'(frac_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         turn_ff  <= TURN_W'(d3_rem) * TURN_W'(DEG_FULL);
         frac_ff  <= d2_base + d2_quo[FRAC_W-1:0];
         f_bad_ff <= d3_bad;
         angle_ff <= angle_in;
         err_ff   <= f_bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, err_ff, angle_ff};

endmodule

FILE: rtl/gcag_checker.sv
// port-level checks of the gait clock angle generator
// depends on gait_clock_angle_generator_unit_defines.svh; bound to the top level
`include "gait_clock_angle_generator_unit_defines.svh"

module gcag_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata
);

   `GCAG_ASSERT_ALWAYS(a_empty_after_reset, reset |=> !rsp_tvalid, "result valid right after reset")
   `GCAG_ASSERT(a_stall_holds, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `GCAG_ASSERT(a_stall_blocks_input, rsp_tvalid && !rsp_tready |-> !req_tready, "input taken while output stalled")
   `GCAG_ASSERT(a_error_zero_angle, rsp_tvalid && rsp_tdata[56] |-> rsp_tdata[55:0] == 56'd0 && rsp_tdata[63:57] == 7'd0, "config error with nonzero angle")

endmodule

bind gait_clock_angle_generator_unit gcag_checker u_gcag_checker (.*);
